/* hw/rtl/mbc_pkg.sv */
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types and constants of the mail body canonicalizer.
// ----------------------------------------------------------------------------
package mbc_pkg;

  localparam int RunCountBits     = 24;
  localparam int PendingCountBits = 24;
  localparam int MaxResults       = 6;
  localparam int ResCountBits     = $clog2(MaxResults + 1);

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  localparam logic ModeSimple  = 1'b0;
  localparam logic ModeRelaxed = 1'b1;

  localparam logic KindByte = 1'b0;
  localparam logic KindRun  = 1'b1;

  // width of the withheld CRLF counter, never wider than a run count
  function automatic int pend_bits(int count_bits);
    return (count_bits < RunCountBits) ? count_bits : RunCountBits;
  endfunction

  // one accepted input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_body;
  } item_t;

  // one result item without its framing flags
  typedef struct packed {
    logic                    kind;
    logic [7:0]              data;
    logic [RunCountBits-1:0] count;
  } res_t;

  // line state carried between items
  typedef struct packed {
    logic held_cr;
    logic in_ws;
    logic line_content;
  } flags_t;

endpackage

/* hw/rtl/mbc_step.sv */
// ----------------------------------------------------------------------------
// mbc_step
// Combinational canonicalization of one item: the list of results it causes
// and the line state it leaves behind.
// ----------------------------------------------------------------------------
module mbc_step #(
  parameter int PendingCountBits = mbc_pkg::PendingCountBits
) (
  input  logic                                            mode,
  input  mbc_pkg::item_t                                  item,
  input  logic [mbc_pkg::pend_bits(PendingCountBits)-1:0] pend,
  input  mbc_pkg::flags_t                                 flags,
  output logic [mbc_pkg::pend_bits(PendingCountBits)-1:0] pend_next,
  output mbc_pkg::flags_t                                 flags_next,
  output mbc_pkg::res_t [mbc_pkg::MaxResults-1:0]         ents,
  output logic [mbc_pkg::ResCountBits-1:0]                ent_count
);

  localparam int PW  = mbc_pkg::pend_bits(PendingCountBits);
  localparam int Max = mbc_pkg::MaxResults;
  localparam int NB  = mbc_pkg::ResCountBits;
  localparam int IB  = (Max > 1) ? $clog2(Max) : 1;

  typedef struct packed {
    logic [PW-1:0]                cnt;
    logic                         held;
    logic                         ws;
    logic                         lc;
    logic [NB-1:0]                n;
    mbc_pkg::res_t [Max-1:0]      ents;
  } ctx_t;

  function automatic ctx_t put(ctx_t c, mbc_pkg::res_t r);
    ctx_t o;
    o = c;
    if (o.n < NB'(Max)) begin
      o.ents[o.n[IB-1:0]] = r;
      o.n = o.n + NB'(1);
    end
    return o;
  endfunction

  function automatic mbc_pkg::res_t byte_res(logic [7:0] ch);
    mbc_pkg::res_t r;
    r.kind  = mbc_pkg::KindByte;
    r.data  = ch;
    r.count = '0;
    return r;
  endfunction

  function automatic mbc_pkg::res_t run_res(logic [mbc_pkg::RunCountBits-1:0] cnt);
    mbc_pkg::res_t r;
    r.kind  = mbc_pkg::KindRun;
    r.data  = '0;
    r.count = cnt;
    return r;
  endfunction

  function automatic ctx_t flush(ctx_t c);
    ctx_t o;
    o = c;
    if (o.cnt != '0) begin
      o = put(o, run_res(mbc_pkg::RunCountBits'(o.cnt)));
      o.cnt = '0;
    end
    return o;
  endfunction

  function automatic ctx_t add_pending(ctx_t c);
    ctx_t o;
    o = c;
    if (o.cnt != {PW{1'b1}}) o.cnt = o.cnt + PW'(1);
    return o;
  endfunction

  // relaxed: write one non-whitespace character of the line
  function automatic ctx_t content(ctx_t c, logic [7:0] ch);
    ctx_t o;
    o = c;
    if (!o.lc) o = flush(o);
    if (o.ws) o = put(o, byte_res(mbc_pkg::ChSp));
    o = put(o, byte_res(ch));
    o.ws = 1'b0;
    o.lc = 1'b1;
    return o;
  endfunction

  function automatic ctx_t resolve_cr(ctx_t c);
    ctx_t o;
    o = c;
    if (o.held) begin
      o.held = 1'b0;
      o = content(o, mbc_pkg::ChCr);
    end
    return o;
  endfunction

  logic  is_lf, is_cr, is_ws;
  ctx_t  c;

  assign is_lf = item.data_byte == mbc_pkg::ChLf;
  assign is_cr = item.data_byte == mbc_pkg::ChCr;
  assign is_ws = (item.data_byte == mbc_pkg::ChSp) || (item.data_byte == mbc_pkg::ChTab);

  always_comb begin
    c.cnt  = pend;
    c.held = flags.held_cr;
    c.ws   = flags.in_ws;
    c.lc   = flags.line_content;
    c.n    = '0;
    c.ents = '0;

    if (item.byte_valid) begin
      if (mode == mbc_pkg::ModeRelaxed) begin
        if (is_lf) begin
          c.held = 1'b0;
          c.ws   = 1'b0;
          c      = add_pending(c);
          c.lc   = 1'b0;
        end else begin
          c = resolve_cr(c);
          if (is_ws) begin
            c.ws = 1'b1;
          end else if (is_cr) begin
            c.held = 1'b1;
          end else begin
            c = content(c, item.data_byte);
          end
        end
      end else begin
        if (is_lf) begin
          c.held = 1'b0;
          c      = add_pending(c);
        end else begin
          c = flush(c);
          if (c.held) begin
            c      = put(c, byte_res(mbc_pkg::ChCr));
            c.held = 1'b0;
          end
          if (is_cr) c.held = 1'b1;
          else       c = put(c, byte_res(item.data_byte));
        end
      end
    end

    if (item.end_of_body) begin
      if (c.held) begin
        if (mode == mbc_pkg::ModeRelaxed) begin
          c = resolve_cr(c);
        end else begin
          c      = flush(c);
          c      = put(c, byte_res(mbc_pkg::ChCr));
          c.held = 1'b0;
        end
      end
      // close the body with one CRLF, drop what is withheld
      c      = put(c, run_res(mbc_pkg::RunCountBits'(1)));
      c.cnt  = '0;
      c.held = 1'b0;
      c.ws   = 1'b0;
      c.lc   = 1'b0;
    end
  end

  assign pend_next               = c.cnt;
  assign flags_next.held_cr      = c.held;
  assign flags_next.in_ws        = c.ws;
  assign flags_next.line_content = c.lc;
  assign ents                    = c.ents;
  assign ent_count               = c.n;

endmodule

/* hw/rtl/mail_body_canonicalizer.sv */
// ----------------------------------------------------------------------------
// mail_body_canonicalizer
// Stream canonicalizer for mail bodies, simple or relaxed per cfg register.
// ----------------------------------------------------------------------------
// Usage: feed raw body bytes on the s_axis channel, one item per byte; tuser
// says whether tdata holds a byte, tlast closes the body (an item may carry
// tlast with no byte). Canonical output leaves on m_axis, one result per
// transfer: a single byte, or a run of CRLF pairs given by a count. m_axis tuser
// marks the result kind and the last result caused by an input item, m_axis
// tlast the final result of the body.
// cfg_wr_en/cfg_wr_data write the mode bit (0 simple, 1 relaxed) while idle.
// Flow: an accepted item is held in the input register, where its results
// are formed combinationally and loaded into the result buffer, from which
// its first result is offered on m_axis.
// Throughput: one input item per cycle while each item causes at most one
// result and m_axis_tready stays high; an item with more results holds the
// result buffer and stalls input until only its last result is left.
// When m_axis_tready is low a non-empty result buffer holds and, once the input
// register is full too, s_axis_tready drops.
// Reset (rst, synchronous) empties both registers, clears the line state
// and sets simple mode.
// ----------------------------------------------------------------------------
module mail_body_canonicalizer #(
  parameter int PendingCountBits = mbc_pkg::PendingCountBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_body
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [31:8] run_count
  output logic [1:0]  m_axis_tuser,   // [0] out_kind, [1] last_of_input
  output logic        m_axis_tlast    // body_done
);

  localparam int PW  = (PendingCountBits < mbc_pkg::RunCountBits) ?
                       PendingCountBits : mbc_pkg::RunCountBits;
  localparam int Max = mbc_pkg::MaxResults;
  localparam int NB  = mbc_pkg::ResCountBits;

  logic                    mode;
  logic                    in_full;
  mbc_pkg::item_t          in_item;
  logic [PW-1:0]           pend;
  mbc_pkg::flags_t         flags;
  mbc_pkg::res_t [Max-1:0] buf_ents;
  logic [NB-1:0]           buf_n;
  logic                    buf_end;

  logic [PW-1:0]           pend_next;
  mbc_pkg::flags_t         flags_next;
  mbc_pkg::res_t [Max-1:0] step_ents;
  logic [NB-1:0]           step_n;

  logic out_fire;
  logic consume;

  mbc_step #(
    .PendingCountBits(PendingCountBits)
  ) u_step (
    .mode      (mode),
    .item      (in_item),
    .pend      (pend),
    .flags     (flags),
    .pend_next (pend_next),
    .flags_next(flags_next),
    .ents      (step_ents),
    .ent_count (step_n)
  );

  assign out_fire      = m_axis_tvalid && m_axis_tready;
  // load a new result list when the buffer is empty or drains this cycle
  assign consume       = in_full && ((buf_n == '0) || ((buf_n == NB'(1)) && m_axis_tready));
  assign s_axis_tready = !in_full || consume;

  assign m_axis_tvalid      = buf_n != '0;
  assign m_axis_tdata       = {buf_ents[0].count, buf_ents[0].data};
  assign m_axis_tuser       = {buf_n == NB'(1), buf_ents[0].kind};
  assign m_axis_tlast       = (buf_n == NB'(1)) && buf_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mbc_pkg::ModeSimple;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_item.data_byte   <= s_axis_tdata;
      in_item.byte_valid  <= s_axis_tuser;
      in_item.end_of_body <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      flags <= '0;
      buf_n <= '0;
    end else if (consume) begin
      pend  <= pend_next;
      flags <= flags_next;
      buf_n <= step_n;
    end else if (out_fire) begin
      buf_n <= buf_n - NB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      buf_ents <= step_ents;
      buf_end  <= in_item.end_of_body;
    end else if (out_fire) begin
      // advance the queue by one result
      for (int i = 0; i < Max - 1; i++) begin
        buf_ents[i] <= buf_ents[i+1];
      end
    end
  end

endmodule
